// File: rtl/mpsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsm_pkg: shared types and constants for the multi-pattern string matcher
// Node and letter widths, mode codes, status codes and the request record.
// ----------------------------------------------------------------------------
package mpsm_pkg;

  localparam int MaxNodes    = 128;
  localparam int Alphabet    = 26;
  localparam int MaxPatterns = 8;
  localparam int NodeW       = 7;
  localparam int LetW        = 5;
  localparam int MaskW       = 8;
  localparam int ChildDepth  = MaxNodes * Alphabet;
  localparam int ChildAw     = 12;
  localparam int QDepth      = 4;
  localparam int QAw         = 2;

  localparam logic [NodeW-1:0] RootNode = NodeW'(1);

  typedef enum logic [2:0] {
    MODE_CLEAR = 3'd0,
    MODE_PLET  = 3'd1,
    MODE_PEND  = 3'd2,
    MODE_BUILD = 3'd3,
    MODE_START = 3'd4,
    MODE_SCAN  = 3'd5,
    MODE_NOP6  = 3'd6,
    MODE_NOP7  = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NOLNK = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  // Classified request passed from front to back
  typedef struct packed {
    mode_t           mode;
    logic [LetW-1:0] letter;
    logic [2:0]      pid;
    logic            let_ok;
    logic            pid_ok;
  } req_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_PL_RD, S_PL_WAIT, S_PL_DEC, S_PE_RD, S_PE_WAIT,
    S_SC_RD, S_SC_WAIT, S_SC_DEC, S_SC_FIN, S_SC_MWAIT,
    S_B_POP, S_B_NRD, S_B_NWAIT, S_B_NDEC, S_B_ARD, S_B_AWAIT, S_B_ADEC,
    S_B_FIN, S_B_MWAIT, S_B_MWR, S_B_CRD, S_B_CWAIT, S_B_CDEC, S_OUT
  } bstate_t;

  function automatic logic [ChildAw-1:0] child_addr(logic [NodeW-1:0] n,
                                                   logic [LetW-1:0] c);
    child_addr = ChildAw'(n) * ChildAw'(Alphabet) + ChildAw'(c);
  endfunction

endpackage

// File: rtl/mpsm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsm_front: request intake and classification
// Unpacks tdata, flags letter and pattern-id range, and queues the request.
// ----------------------------------------------------------------------------
module mpsm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [15:0]         s_tdata,
  output logic                q_valid,
  input  logic                q_pop,
  output mpsm_pkg::req_t      q_req
);
  import mpsm_pkg::*;

  req_t          mem [QDepth];
  logic [QAw-1:0] wp, rp;
  logic [QAw:0]   cnt;
  req_t          req_in;
  logic          push;

  // Classify the incoming request
  always_comb begin
    req_in.mode   = mode_t'(s_tdata[2:0]);
    req_in.letter = s_tdata[7:3];
    req_in.pid    = s_tdata[10:8];
    req_in.let_ok = (s_tdata[7:3] < LetW'(Alphabet));
    req_in.pid_ok = ({1'b0, s_tdata[10:8]} < 4'(MaxPatterns));
  end

  assign s_tready = (cnt != (QAw+1)'(QDepth));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (cnt != '0);
  assign q_req    = mem[rp];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= req_in;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (q_pop) rp <= rp + 1'b1;
      cnt <= cnt + (QAw+1)'(push) - (QAw+1)'(q_pop);
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (rst)
    cnt <= (QAw+1)'(QDepth)) else $error("queue count overflow");
  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    (push && !q_pop) |=> cnt == $past(cnt) + 1'b1) else $error("count slip");

endmodule

// File: rtl/mpsm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsm_back: trie engine
// Carries out one request at a time over the child memory and node tables;
// builds failure links by a breadth-first sweep with a node queue.
// ----------------------------------------------------------------------------
module mpsm_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_pop,
  input  mpsm_pkg::req_t      q_req,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [31:0]         m_tdata
);
  import mpsm_pkg::*;

  bstate_t state, state_next;

  // Memories
  logic [NodeW-1:0] child_mem [ChildDepth];
  logic [NodeW-1:0] fail_mem  [MaxNodes];
  logic [NodeW-1:0] par_mem   [MaxNodes];
  logic [LetW-1:0]  plet_mem  [MaxNodes];
  logic [NodeW-1:0] dep_mem   [MaxNodes];
  logic [MaskW-1:0] mask_mem  [MaxNodes];
  logic [NodeW-1:0] bfs_mem   [MaxNodes];

  logic [NodeW-1:0] child_rd, fail_rd, par_rd, dep_rd, bfs_rd;
  logic [LetW-1:0]  plet_rd;
  logic [MaskW-1:0] mask_rd;
  logic [ChildAw-1:0] c_addr;
  logic [NodeW-1:0]   t_addr;
  logic [NodeW-1:0]   bfs_addr;

  // Write controls
  logic c_we, f_we, n_we, m_we, b_we;
  logic [ChildAw-1:0] c_waddr;
  logic [NodeW-1:0]   c_wdata, f_waddr, f_wdata, n_waddr, m_waddr, b_waddr, b_wdata;
  logic [MaskW-1:0]   m_wdata;
  logic [NodeW-1:0]   n_par, n_dep;
  logic [LetW-1:0]    n_let;

  // Architectural registers
  logic [NodeW-1:0] node_count, ins_cur, scan_node;
  logic [MaskW-1:0] seen;
  logic             built;
  logic [ChildAw-1:0] clr_idx;
  logic             clr_reply;
  req_t             rq;

  // Walk and build registers
  logic [NodeW-1:0] cur, bn, bp, bhead, btail;
  logic [LetW-1:0]  wlet, ci;
  logic [NodeW:0]   guard;
  logic [NodeW-1:0] o_node;
  logic [MaskW-1:0] o_hit;
  status_t          o_st;
  logic [MaskW-1:0] bmask;
  logic             in_build;

  // Child memory
  always_ff @(posedge clk) begin
    if (c_we) child_mem[c_waddr] <= c_wdata;
    child_rd <= child_mem[c_addr];
  end

  // Node tables
  always_ff @(posedge clk) begin
    if (f_we) fail_mem[f_waddr] <= f_wdata;
    if (n_we) begin
      par_mem[n_waddr]  <= n_par;
      plet_mem[n_waddr] <= n_let;
      dep_mem[n_waddr]  <= n_dep;
    end
    if (m_we) mask_mem[m_waddr] <= m_wdata;
    if (b_we) bfs_mem[b_waddr] <= b_wdata;
    fail_rd <= fail_mem[t_addr];
    par_rd  <= par_mem[t_addr];
    plet_rd <= plet_mem[t_addr];
    dep_rd  <= dep_mem[t_addr];
    mask_rd <= mask_mem[t_addr];
    bfs_rd  <= bfs_mem[bfs_addr];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          unique case (q_req.mode)
            MODE_CLEAR: state_next = S_CLR;
            MODE_PLET:  state_next = (q_req.let_ok && ins_cur != '0) ? S_PL_RD : S_OUT;
            MODE_PEND:  state_next = (ins_cur != '0 && q_req.pid_ok) ? S_PE_RD : S_OUT;
            MODE_BUILD: state_next = S_B_POP;
            MODE_SCAN:  state_next = !built ? S_OUT : (q_req.let_ok ? S_SC_RD : S_SC_FIN);
            default:    state_next = S_OUT;
          endcase
        end
      end
      S_CLR: begin
        if (clr_idx == ChildAw'(ChildDepth - 1)) state_next = clr_reply ? S_OUT : S_IDLE;
      end
      S_PL_RD:    state_next = S_PL_WAIT;
      S_PL_WAIT:  state_next = S_PL_DEC;
      S_PL_DEC:   state_next = S_OUT;
      S_PE_RD:    state_next = S_PE_WAIT;
      S_PE_WAIT:  state_next = S_OUT;
      S_SC_RD:    state_next = S_SC_WAIT;
      S_SC_WAIT:  state_next = S_SC_DEC;
      S_SC_DEC: begin
        if (child_rd != '0 || cur <= RootNode || guard == (NodeW+1)'(MaxNodes))
          state_next = in_build ? S_B_FIN : S_SC_FIN;
        else
          state_next = S_SC_RD;
      end
      S_SC_FIN:   state_next = S_SC_MWAIT;
      S_SC_MWAIT: state_next = S_OUT;
      S_B_POP: begin
        if (bhead == '0 && btail == '0) state_next = S_B_POP;
        else if (bhead == btail) state_next = S_OUT;
        else state_next = S_B_NRD;
      end
      S_B_NRD:    state_next = S_B_NWAIT;
      S_B_NWAIT:  state_next = S_B_NDEC;
      S_B_NDEC:   state_next = (dep_rd <= NodeW'(1)) ? S_B_CRD : S_B_ARD;
      S_B_ARD:    state_next = S_B_AWAIT;
      S_B_AWAIT:  state_next = S_B_ADEC;
      S_B_ADEC:   state_next = S_SC_RD;
      S_B_FIN:    state_next = S_B_MWAIT;
      S_B_MWAIT:  state_next = S_B_MWR;
      S_B_MWR:    state_next = S_B_CRD;
      S_B_CRD:    state_next = S_B_CWAIT;
      S_B_CWAIT:  state_next = S_B_CDEC;
      S_B_CDEC:   state_next = (ci == LetW'(Alphabet - 1)) ? S_B_POP : S_B_CRD;
      S_OUT:      if (m_tready) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Memory addresses and write strobes
  always_comb begin
    c_addr   = child_addr(cur, wlet);
    t_addr   = cur;
    bfs_addr = bhead;
    c_we = 1'b0; c_waddr = clr_idx; c_wdata = '0;
    f_we = 1'b0; f_waddr = bn; f_wdata = RootNode;
    n_we = 1'b0; n_waddr = node_count + 1'b1; n_par = ins_cur; n_let = rq.letter;
    n_dep = dep_rd + 1'b1;
    m_we = 1'b0; m_waddr = ins_cur; m_wdata = mask_rd | (MaskW'(1) << rq.pid);
    b_we = 1'b0; b_waddr = btail; b_wdata = child_rd;
    unique case (state)
      S_CLR: begin
        c_we = 1'b1;
        if (clr_idx < ChildAw'(MaxNodes)) begin
          f_we = 1'b1; f_waddr = clr_idx[NodeW-1:0];
          n_we = 1'b1; n_waddr = clr_idx[NodeW-1:0]; n_par = '0; n_let = '0; n_dep = '0;
          m_we = 1'b1; m_waddr = clr_idx[NodeW-1:0]; m_wdata = '0;
        end
      end
      S_PL_RD, S_PL_WAIT: t_addr = ins_cur;
      S_PL_DEC: begin
        if (child_rd == '0 && node_count != NodeW'(MaxNodes - 1)) begin
          c_we = 1'b1; c_waddr = child_addr(ins_cur, rq.letter);
          c_wdata = node_count + 1'b1;
          n_we = 1'b1;
        end
      end
      S_PE_RD, S_PE_WAIT: t_addr = ins_cur;
      // Read the mask of the node the scan lands on
      S_SC_FIN: t_addr = (rq.let_ok && child_rd != '0) ? child_rd : cur;
      S_B_POP: begin
        b_we = (bhead == '0 && btail == '0);
        b_wdata = RootNode;
      end
      S_B_NRD, S_B_NWAIT, S_B_NDEC: t_addr = bn;
      S_B_ARD, S_B_AWAIT: t_addr = bp;
      S_B_FIN, S_B_MWAIT: t_addr = cur;
      S_B_MWR: begin
        f_we = 1'b1; f_wdata = cur;
        t_addr = bn;
      end
      S_B_CRD, S_B_CWAIT: c_addr = child_addr(bn, ci);
      S_B_CDEC: b_we = (child_rd != '0) && (btail != '0);
      default: ;
    endcase
    if (state == S_PE_WAIT && ins_cur != '0 && rq.pid_ok) m_we = 1'b1;
    if (state == S_B_MWR) begin
      m_we = 1'b1; m_waddr = bn; m_wdata = bmask | mask_rd;
    end
    if (state == S_B_NDEC && dep_rd <= NodeW'(1)) f_we = 1'b1;
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  // Request sequencing and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_idx <= '0;
      clr_reply <= 1'b0;
      node_count <= NodeW'(1);
      ins_cur <= RootNode;
      scan_node <= RootNode;
      seen <= '0;
      built <= 1'b0;
      in_build <= 1'b0;
      rq <= '0;
      o_node <= RootNode; o_hit <= '0; o_st <= ST_OK;
      bhead <= '0; btail <= '0; guard <= '0;
      cur <= RootNode; wlet <= '0; ci <= '0; bn <= RootNode; bp <= '0; bmask <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: if (q_valid) begin
          rq <= q_req;
          o_hit <= '0; o_st <= ST_OK; o_node <= scan_node;
          cur <= scan_node; wlet <= q_req.letter; guard <= '0; in_build <= 1'b0;
          bhead <= '0; btail <= '0;
          unique case (q_req.mode)
            MODE_CLEAR: begin
              clr_idx <= '0; clr_reply <= 1'b1;
            end
            MODE_PLET: begin
              if (q_req.let_ok) begin
                built <= 1'b0;
                if (ins_cur == '0) o_st <= ST_FULL;
                else cur <= ins_cur;
              end
              o_node <= ins_cur;
            end
            MODE_PEND: begin
              built <= 1'b0;
              o_node <= (ins_cur != '0 && q_req.pid_ok) ? ins_cur : '0;
              if (!(ins_cur != '0 && q_req.pid_ok)) ins_cur <= RootNode;
            end
            MODE_START: begin
              scan_node <= RootNode; seen <= '0; o_node <= RootNode;
            end
            MODE_SCAN: begin
              if (!built) o_st <= ST_NOLNK;
              else if (!q_req.let_ok) cur <= RootNode;
            end
            default: ;
          endcase
        end
        S_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == ChildAw'(ChildDepth - 1)) begin
            node_count <= NodeW'(1); ins_cur <= RootNode; scan_node <= RootNode;
            seen <= '0; built <= 1'b0; o_node <= RootNode;
          end
        end
        S_PL_DEC: begin
          if (child_rd != '0) begin
            ins_cur <= child_rd; o_node <= child_rd;
          end else if (node_count == NodeW'(MaxNodes - 1)) begin
            ins_cur <= '0; o_node <= '0; o_st <= ST_FULL;
          end else begin
            node_count <= node_count + 1'b1;
            ins_cur <= node_count + 1'b1; o_node <= node_count + 1'b1;
          end
        end
        S_PE_WAIT: ins_cur <= RootNode;
        S_SC_DEC: begin
          if (!(child_rd != '0 || cur <= RootNode || guard == (NodeW+1)'(MaxNodes))) begin
            cur <= fail_rd; guard <= guard + 1'b1;
          end else if (cur <= RootNode) begin
            cur <= RootNode;
          end
        end
        S_SC_FIN: begin
          // Child of the landing node was read; fall back when absent
          if (built && rq.let_ok && child_rd != '0 && cur >= RootNode) cur <= child_rd;
        end
        S_SC_MWAIT: begin
          scan_node <= cur; o_node <= cur; o_hit <= mask_rd; seen <= seen | mask_rd;
        end
        S_B_POP: begin
          if (bhead == '0 && btail == '0) begin
            btail <= NodeW'(1);
            bn <= RootNode;
          end else if (bhead == btail) begin
            built <= 1'b1; o_node <= scan_node;
          end
        end
        S_B_NRD: bn <= bfs_rd;
        S_B_NDEC: begin
          bhead <= bhead + 1'b1;
          bp <= par_rd; wlet <= plet_rd; ci <= '0;
          bmask <= mask_rd;
          in_build <= 1'b1;
        end
        S_B_ADEC: begin
          cur <= fail_rd; guard <= '0;
        end
        S_B_FIN: if (child_rd != '0 && cur >= RootNode) cur <= child_rd;
        S_B_CDEC: begin
          if (child_rd != '0 && btail != '0) btail <= btail + 1'b1;
          ci <= ci + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {7'd0, o_st, seen, o_hit, o_node};

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == S_IDLE) else $error("pop outside idle");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    node_count < NodeW'(MaxNodes - 1) || node_count == NodeW'(MaxNodes - 1))
    else $error("node count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");

endmodule

// File: rtl/multi_pattern_string_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher: Aho-Corasick matcher top level
// Front intake queue feeding a trie engine with failure-link build.
// ----------------------------------------------------------------------------
//  group   dir  contents
//  s_*     in   request: tdata = mode[2:0], letter[7:3], pattern_id[10:8]
//  m_*     out  result: tdata = node[6:0], hit_mask[14:7], seen_mask[22:15],
//                       status[24:23]
//
// Scan follows failure links until a child is found, reading the child memory
// and the fail table for each link followed.
// Build walks the trie breadth first, following failure links for nodes
// deeper than one.
// After reset and on clear the child memory is swept while requests wait in
// the front queue. The front queue holds 4 requests; results stall on m_tready.
module multi_pattern_string_matcher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // mode, letter, pattern_id
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // node, hit_mask, seen_mask, status
);
  import mpsm_pkg::*;

  req_t q_req;
  logic q_valid, q_pop;

  mpsm_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .q_valid, .q_pop, .q_req
  );

  mpsm_back u_back (
    .clk, .rst, .q_valid, .q_pop, .q_req,
    .m_tvalid, .m_tready, .m_tdata
  );

endmodule

// File: sim/multi_pattern_string_matcher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher_tb: self-checking bench for the string matcher
// Walks a directed table (empty trie, mask extremes, unused modes, empty
// pattern, out-of-alphabet letters, scan before build, clear), fills the trie
// to overflow, then runs random pattern/build/scan sessions mixed with noise.
// Results match the directed table or a behavioral trie model in the bench.
// ----------------------------------------------------------------------------
module multi_pattern_string_matcher_tb;
  import mpsm_pkg::*;

  localparam int WatchLimit = 60000;
  localparam int LongHold   = 400;

  typedef struct packed {
    logic [NodeW-1:0] node;
    logic [MaskW-1:0] hit;
    logic [MaskW-1:0] seen;
    status_t          status;
  } match_t;

  typedef struct {
    mode_t      mode;
    logic [4:0] letter;
    logic [2:0] pid;
    bit         typed;
    match_t     res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  // trie shadow
  logic [NodeW-1:0] kid [MaxNodes*Alphabet];
  logic [NodeW-1:0] fail_of [MaxNodes];
  logic [NodeW-1:0] par_of [MaxNodes];
  logic [LetW-1:0]  plet_of [MaxNodes];
  logic [NodeW-1:0] depth_of [MaxNodes];
  logic [MaskW-1:0] mask_of [MaxNodes];
  int               nodes_used;
  logic [NodeW-1:0] cursor, scan_at;
  logic [MaskW-1:0] seen_acc;
  bit               linked;

  match_t results_due [$];
  int     err_cnt = 0;
  bit     hold_req = 1'b0;
  bit     done = 1'b0;

  multi_pattern_string_matcher DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void trie_clear();
    for (int i = 0; i < MaxNodes*Alphabet; i++) kid[i] = '0;
    for (int i = 0; i < MaxNodes; i++) begin
      fail_of[i] = RootNode; par_of[i] = '0; plet_of[i] = '0;
      depth_of[i] = '0; mask_of[i] = '0;
    end
    nodes_used = 1; cursor = RootNode; scan_at = RootNode;
    seen_acc = '0; linked = 1'b0;
  endfunction

  function automatic int kid_of(int n, int c);
    if (n >= MaxNodes || c >= Alphabet) return 0;
    return kid[n*Alphabet + c];
  endfunction

  // follow failure links until a node has a child on c
  function automatic int goto_next(int n, int c);
    int cur, guard, nx;
    cur = n; guard = 0;
    while (cur > 1 && cur < MaxNodes && kid_of(cur, c) == 0 && guard < MaxNodes) begin
      cur = fail_of[cur]; guard++;
    end
    if (cur >= MaxNodes || cur == 0) cur = 1;
    nx = kid_of(cur, c);
    return (nx != 0) ? nx : cur;
  endfunction

  // breadth-first failure links, masks merged along the way
  function automatic void link_trie();
    int order [MaxNodes];
    int head, tail, n, f, k;
    head = 0; tail = 1; order[0] = 1;
    while (head < tail) begin
      n = order[head++];
      if (depth_of[n] <= 1) fail_of[n] = RootNode;
      else begin
        f = goto_next(fail_of[par_of[n]], plet_of[n]);
        fail_of[n] = NodeW'(f);
        mask_of[n] |= mask_of[f];
      end
      for (int c = 0; c < Alphabet; c++) begin
        k = kid[n*Alphabet + c];
        if (k != 0 && tail < MaxNodes) order[tail++] = k;
      end
    end
    linked = 1'b1;
  endfunction

  function automatic match_t match_step(mode_t md, logic [4:0] ltr, logic [2:0] pid);
    match_t r;
    int nn, k;
    r = '{node: scan_at, hit: '0, seen: '0, status: ST_OK};
    case (md)
      MODE_CLEAR: begin
        trie_clear(); r.node = scan_at;
      end
      MODE_PLET: begin
        if (ltr < Alphabet) begin
          linked = 1'b0;
          if (cursor == 0) r.status = ST_FULL;
          else begin
            k = kid_of(cursor, ltr);
            if (k != 0) cursor = NodeW'(k);
            else if (nodes_used + 1 >= MaxNodes) begin
              cursor = '0; r.status = ST_FULL;
            end else begin
              nn = ++nodes_used;
              kid[cursor*Alphabet + ltr] = NodeW'(nn);
              par_of[nn] = cursor; plet_of[nn] = ltr;
              depth_of[nn] = depth_of[cursor] + 1'b1;
              cursor = NodeW'(nn);
            end
          end
        end
        r.node = cursor;
      end
      MODE_PEND: begin
        linked = 1'b0; r.node = '0;
        if (cursor != 0 && pid < MaxPatterns) begin
          mask_of[cursor] |= MaskW'(1) << pid;
          r.node = cursor;
        end
        cursor = RootNode;
      end
      MODE_BUILD: begin
        link_trie(); r.node = scan_at;
      end
      MODE_START: begin
        scan_at = RootNode; seen_acc = '0; r.node = scan_at;
      end
      MODE_SCAN: begin
        if (!linked) r.status = ST_NOLNK;
        else begin
          scan_at = (ltr < Alphabet) ? NodeW'(goto_next(scan_at, ltr)) : RootNode;
          r.hit = mask_of[scan_at];
          seen_acc |= r.hit;
        end
        r.node = scan_at;
      end
      default: ;
    endcase
    r.seen = seen_acc;
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // offer one request, record its expected result once taken
  task automatic put_req(mode_t md, logic [4:0] ltr, logic [2:0] pid,
                         bit typed = 1'b0, match_t res = '0, bit no_gap = 1'b0);
    match_t r;
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, pid, ltr, md};
    do @(posedge clk); while (!s_tready);
    r = match_step(md, ltr, pid);
    results_due.insert(results_due.size(), typed ? res : r);
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drop_req();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: random stalls, calm stretches, one long hold on request
  initial begin
    int calm;
    calm = 0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        hold_req = 1'b0;
      end
      if (calm > 0) begin
        calm--;
        m_tready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(99) < 3) begin
        calm = $urandom_range(60, 20);
      end else begin
        m_tready <= ($urandom_range(99) < 70);
        if ($urandom_range(99) < 3) repeat ($urandom_range(40, 10)) @(posedge clk);
        else @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    match_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{node: m_tdata[6:0], hit: m_tdata[14:7], seen: m_tdata[22:15],
              status: status_t'(m_tdata[24:23])};
      if (results_due.size() == 0) begin
        $error("unexpected result %h", m_tdata);
        err_cnt++;
      end else begin
        want = results_due.pop_front();
        if (got.node !== want.node) begin
          $error("node: expected %0d, got %0d", want.node, got.node); err_cnt++;
        end
        if (got.hit !== want.hit) begin
          $error("hit_mask: expected %h, got %h", want.hit, got.hit); err_cnt++;
        end
        if (got.seen !== want.seen) begin
          $error("seen_mask: expected %h, got %h", want.seen, got.seen); err_cnt++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status); err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    int idle;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || done) idle = 0;
    else begin
      idle++;
      if (idle >= WatchLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic logic [4:0] rand_let(int asz);
    if ($urandom_range(99) < 4) return 5'($urandom_range(31, 26));
    return 5'($urandom_range(asz - 1));
  endfunction

  // one session: optional clear, patterns, optional build, start, scan text
  task automatic run_session(ref int sent);
    int asz, npat, plen, ntext;
    asz = ($urandom_range(99) < 80) ? $urandom_range(4, 2) : Alphabet;
    if ($urandom_range(99) < 8) begin
      put_req(MODE_CLEAR, 5'($urandom), 3'($urandom)); sent++;
    end
    npat = $urandom_range(4, 1);
    for (int p = 0; p < npat; p++) begin
      plen = $urandom_range(4, 1);
      for (int i = 0; i < plen; i++) begin
        put_req(MODE_PLET, rand_let(asz), 3'($urandom)); sent++;
      end
      if ($urandom_range(99) < 5) begin
        put_req(mode_t'($urandom_range(7, 6)), 5'($urandom), 3'($urandom)); sent++;
      end
      put_req(MODE_PEND, 5'($urandom), 3'($urandom)); sent++;
    end
    if ($urandom_range(99) < 90) begin
      put_req(MODE_BUILD, 5'($urandom), 3'($urandom)); sent++;
    end
    put_req(MODE_START, 5'($urandom), 3'($urandom)); sent++;
    ntext = $urandom_range(40, 8);
    for (int i = 0; i < ntext; i++) begin
      if ($urandom_range(99) < 3) put_req(MODE_START, 5'($urandom), 3'($urandom));
      else put_req(MODE_SCAN, rand_let(asz), 3'($urandom));
      sent++;
    end
  endtask

  initial begin
    row_t dir_rows [$];
    int sent;
    trie_clear();
    // after reset the trie is empty and links are not built
    dir_rows = '{
      '{MODE_SCAN,  5'd0,  3'd0, 1, '{7'd1, 8'h00, 8'h00, ST_NOLNK}},
      '{MODE_NOP6,  5'd31, 3'd7, 1, '{7'd1, 8'h00, 8'h00, ST_OK}},
      '{MODE_NOP7,  5'd0,  3'd0, 1, '{7'd1, 8'h00, 8'h00, ST_OK}},
      '{MODE_PLET,  5'd0,  3'd0, 1, '{7'd2, 8'h00, 8'h00, ST_OK}},
      '{MODE_PLET,  5'd31, 3'd0, 1, '{7'd2, 8'h00, 8'h00, ST_OK}},
      '{MODE_PEND,  5'd0,  3'd0, 1, '{7'd2, 8'h00, 8'h00, ST_OK}},
      '{MODE_PLET,  5'd1,  3'd0, 1, '{7'd3, 8'h00, 8'h00, ST_OK}},
      '{MODE_PLET,  5'd25, 3'd0, 1, '{7'd4, 8'h00, 8'h00, ST_OK}},
      '{MODE_PEND,  5'd0,  3'd7, 1, '{7'd4, 8'h00, 8'h00, ST_OK}},
      '{MODE_BUILD, 5'd0,  3'd0, 1, '{7'd1, 8'h00, 8'h00, ST_OK}},
      '{MODE_START, 5'd0,  3'd0, 1, '{7'd1, 8'h00, 8'h00, ST_OK}},
      '{MODE_SCAN,  5'd0,  3'd0, 1, '{7'd2, 8'h01, 8'h01, ST_OK}},
      '{MODE_SCAN,  5'd1,  3'd0, 1, '{7'd3, 8'h00, 8'h01, ST_OK}},
      '{MODE_SCAN,  5'd25, 3'd0, 1, '{7'd4, 8'h80, 8'h81, ST_OK}},
      '{MODE_SCAN,  5'd31, 3'd0, 1, '{7'd1, 8'h00, 8'h81, ST_OK}},
      '{MODE_SCAN,  5'd25, 3'd0, 1, '{7'd1, 8'h00, 8'h81, ST_OK}},
      '{MODE_PEND,  5'd0,  3'd3, 1, '{7'd1, 8'h00, 8'h81, ST_OK}},
      '{MODE_SCAN,  5'd2,  3'd0, 1, '{7'd1, 8'h00, 8'h81, ST_NOLNK}},
      '{MODE_BUILD, 5'd0,  3'd0, 1, '{7'd1, 8'h00, 8'h81, ST_OK}},
      '{MODE_SCAN,  5'd2,  3'd0, 1, '{7'd1, 8'h08, 8'h89, ST_OK}},
      '{MODE_SCAN,  5'd0,  3'd0, 0, '0},
      '{MODE_START, 5'd0,  3'd0, 1, '{7'd1, 8'h00, 8'h00, ST_OK}},
      '{MODE_CLEAR, 5'd0,  3'd0, 1, '{7'd1, 8'h00, 8'h00, ST_OK}}
    };
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    sent = 0;
    foreach (dir_rows[i]) begin
      put_req(dir_rows[i].mode, dir_rows[i].letter, dir_rows[i].pid,
              dir_rows[i].typed, dir_rows[i].res);
      sent++;
    end

    // overflow the trie with long patterns over the full alphabet
    for (int p = 0; p < 22; p++) begin
      for (int i = 0; i < 7; i++) begin
        put_req(MODE_PLET, 5'($urandom_range(25)), 3'($urandom)); sent++;
      end
      put_req(MODE_PEND, 5'($urandom), 3'($urandom)); sent++;
    end
    put_req(MODE_BUILD, 5'd0, 3'd0); sent++;
    put_req(MODE_START, 5'd0, 3'd0); sent++;
    for (int i = 0; i < 20; i++) begin
      put_req(MODE_SCAN, 5'($urandom_range(25)), 3'd0); sent++;
    end
    put_req(MODE_CLEAR, 5'd0, 3'd0); sent++;

    // random sessions, with a receiver hold and a sender drain on the way
    while (sent < 750) begin
      run_session(sent);
      if (sent > 250 && sent < 320 && !hold_req) begin
        hold_req = 1'b1;
        for (int i = 0; i < 24; i++) begin
          put_req(MODE_SCAN, 5'($urandom_range(3)), 3'd0, 1'b0, '0, 1'b1);
          sent++;
        end
        drop_req();
        wait (results_due.size() == 0);
      end
    end
    s_tvalid <= 1'b0;

    wait (results_due.size() == 0);
    repeat (200) @(posedge clk);
    done = 1'b1;
    if (err_cnt == 0 && results_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
